[sv/letok_pkg.sv]
// shared types and constants of the logic expression tokenizer
`default_nettype none

package letok_pkg;

    // widths of the position and length fields
    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 8;
    localparam int KW_BITS  = 40;

    // saturation limit of an identifier length
    localparam logic [LEN_BITS-1:0] MAX_NAME_LENGTH = 8'd255;

    // token kinds
    typedef enum logic [3:0] {
        KIND_LPAREN   = 4'd0,
        KIND_RPAREN   = 4'd1,
        KIND_THEN     = 4'd2,
        KIND_EQUIV    = 4'd3,
        KIND_TRUE     = 4'd4,
        KIND_FALSE    = 4'd5,
        KIND_AND      = 4'd6,
        KIND_OR       = 4'd7,
        KIND_NOT      = 4'd8,
        KIND_VARIABLE = 4'd9,
        KIND_END      = 4'd10,
        KIND_ERROR    = 4'd11
    } kind_t;

    // scanner modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_NAME   = 6'b000010,
        MODE_DASH   = 6'b000100,
        MODE_LT     = 6'b001000,
        MODE_LTDASH = 6'b010000,
        MODE_ERROR  = 6'b100000
    } mode_t;

    // one token as it leaves the block
    typedef struct packed {
        kind_t               kind;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
    } token_t;

    // all tokens caused by one character beat, slot 0 first
    typedef struct packed {
        token_t [2:0] slots;
        logic   [1:0] count;
    } bundle_t;

    // keyword kind of a closed identifier, variable when no keyword matches
    function automatic kind_t keyword_kind(logic [KW_BITS-1:0] window,
                                           logic [LEN_BITS-1:0] len);
        kind_t k;
        k = KIND_VARIABLE;
        priority if (len == 8'd1 && (window == 40'h54 || window == 40'h74))
            k = KIND_TRUE;
        else if (len == 8'd1 && (window == 40'h46 || window == 40'h66))
            k = KIND_FALSE;
        else if (len == 8'd2 && (window == 40'h4F72 || window == 40'h6F72))
            k = KIND_OR;
        else if (len == 8'd3 && (window == 40'h416E64 || window == 40'h616E64))
            k = KIND_AND;
        else if (len == 8'd3 && (window == 40'h4E6F74 || window == 40'h6E6F74))
            k = KIND_NOT;
        else if (len == 8'd4 && (window == 40'h54727565 || window == 40'h74727565))
            k = KIND_TRUE;
        else if (len == 8'd5 && (window == 40'h46616C7365 || window == 40'h66616C7365))
            k = KIND_FALSE;
        else
            k = KIND_VARIABLE;
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/letok_lexer.sv]
// scanner state and per-character token decode
`default_nettype none

module letok_lexer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               fire,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               last,
    output letok_pkg::bundle_t                      res
);

    typedef struct packed {
        letok_pkg::mode_t                        mode;
        logic [letok_pkg::KW_BITS-1:0]           window;
        logic [letok_pkg::LEN_BITS-1:0]          name_len;
        logic [letok_pkg::POS_BITS-1:0]          start;
    } lex_state_t;

    typedef struct packed {
        lex_state_t         st;
        logic               e0;
        letok_pkg::token_t  t0;
        logic               e1;
        letok_pkg::token_t  t1;
    } step_t;

    typedef struct packed {
        lex_state_t         st;
        logic               e;
        letok_pkg::token_t  t;
    } idle_res_t;

    lex_state_t                        state_reg, state_next;
    logic [letok_pkg::POS_BITS-1:0]    pos_reg, pos_next;
    step_t                             step_a, step_b;
    logic [letok_pkg::POS_BITS-1:0]    pos_after;
    logic                              cand_v [4];
    letok_pkg::token_t                 cand_t [4];

    // character classes
    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // length from start through p, saturating
    function automatic logic [letok_pkg::LEN_BITS-1:0] span(
        logic [letok_pkg::POS_BITS-1:0] p, logic [letok_pkg::POS_BITS-1:0] s);
        logic [letok_pkg::POS_BITS-1:0] d;
        logic [letok_pkg::POS_BITS:0]   n;
        d = p - s;
        n = {1'b0, d} + 1'b1;
        return (n > (letok_pkg::POS_BITS+1)'(255)) ? 8'hFF : n[letok_pkg::LEN_BITS-1:0];
    endfunction

    function automatic letok_pkg::token_t mk_tok(letok_pkg::kind_t k,
        logic [letok_pkg::POS_BITS-1:0] s, logic [letok_pkg::LEN_BITS-1:0] l);
        letok_pkg::token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        return t;
    endfunction

    // a character seen with no token open
    function automatic idle_res_t idle_step(lex_state_t s, logic [7:0] c,
                                            logic [letok_pkg::POS_BITS-1:0] p);
        idle_res_t r;
        r.st       = s;
        r.st.start = p;
        r.e        = 1'b0;
        r.t        = mk_tok(letok_pkg::KIND_ERROR, p, 8'd1);
        priority if (is_space(c))
        begin
            r.e = 1'b0;
        end
        else if (is_letter(c) || c == 8'h5F)
        begin
            r.st.mode     = letok_pkg::MODE_NAME;
            r.st.window   = {32'd0, c};
            r.st.name_len = 8'd1;
        end
        else if (c == 8'h28)
        begin
            r.e = 1'b1;
            r.t = mk_tok(letok_pkg::KIND_LPAREN, p, 8'd1);
        end
        else if (c == 8'h29)
        begin
            r.e = 1'b1;
            r.t = mk_tok(letok_pkg::KIND_RPAREN, p, 8'd1);
        end
        else if (c == 8'h2D)
        begin
            r.st.mode = letok_pkg::MODE_DASH;
        end
        else if (c == 8'h3C)
        begin
            r.st.mode = letok_pkg::MODE_LT;
        end
        else
        begin
            r.e       = 1'b1;
            r.st.mode = letok_pkg::MODE_ERROR;
        end
        return r;
    endfunction

    // one character against the current mode
    function automatic step_t char_step(lex_state_t s, logic [7:0] c,
                                        logic [letok_pkg::POS_BITS-1:0] p);
        step_t     r;
        idle_res_t ir;
        lex_state_t closed;
        closed          = s;
        closed.mode     = letok_pkg::MODE_IDLE;
        closed.window   = '0;
        closed.name_len = '0;
        r.st = s;
        r.e0 = 1'b0;
        r.t0 = mk_tok(letok_pkg::KIND_ERROR, s.start, span(p, s.start));
        r.e1 = 1'b0;
        r.t1 = r.t0;
        ir   = idle_step(s, c, p);
        unique case (s.mode)
            letok_pkg::MODE_IDLE:
            begin
                r.st = ir.st;
                r.e0 = ir.e;
                r.t0 = ir.t;
            end
            letok_pkg::MODE_NAME:
            begin
                if (is_letter(c) || is_digit(c) || c == 8'h5F)
                begin
                    if (s.name_len < 8'd5)
                        r.st.window = {s.window[letok_pkg::KW_BITS-9:0], c};
                    if (s.name_len < letok_pkg::MAX_NAME_LENGTH)
                        r.st.name_len = s.name_len + 8'd1;
                end
                else
                begin
                    ir   = idle_step(closed, c, p);
                    r.e0 = 1'b1;
                    r.t0 = mk_tok(letok_pkg::keyword_kind(s.window, s.name_len),
                                  s.start, s.name_len);
                    r.st = ir.st;
                    r.e1 = ir.e;
                    r.t1 = ir.t;
                end
            end
            letok_pkg::MODE_DASH:
            begin
                r.e0 = 1'b1;
                if (c == 8'h3E)
                begin
                    r.t0      = mk_tok(letok_pkg::KIND_THEN, s.start, 8'd2);
                    r.st.mode = letok_pkg::MODE_IDLE;
                end
                else
                    r.st.mode = letok_pkg::MODE_ERROR;
            end
            letok_pkg::MODE_LT:
            begin
                if (c == 8'h2D)
                    r.st.mode = letok_pkg::MODE_LTDASH;
                else
                begin
                    r.e0      = 1'b1;
                    r.st.mode = letok_pkg::MODE_ERROR;
                end
            end
            letok_pkg::MODE_LTDASH:
            begin
                r.e0 = 1'b1;
                if (c == 8'h3E)
                begin
                    r.t0      = mk_tok(letok_pkg::KIND_EQUIV, s.start, 8'd3);
                    r.st.mode = letok_pkg::MODE_IDLE;
                end
                else
                    r.st.mode = letok_pkg::MODE_ERROR;
            end
            default:
            begin
                r.st.mode = letok_pkg::MODE_ERROR;
            end
        endcase
        return r;
    endfunction

    // the character, then an appended space when it ends the expression
    always_comb
    begin
        pos_after = pos_reg + 1'b1;
        step_a    = char_step(state_reg, char_code, pos_reg);
        step_b    = char_step(step_a.st, 8'd32, pos_after);
    end

    // gather up to three tokens in order
    always_comb
    begin
        logic [2:0] n;
        cand_v[0] = step_a.e0;
        cand_t[0] = step_a.t0;
        cand_v[1] = step_a.e1;
        cand_t[1] = step_a.t1;
        cand_v[2] = last && step_b.e0;
        cand_t[2] = step_b.t0;
        cand_v[3] = last;
        cand_t[3] = mk_tok(letok_pkg::KIND_END, pos_after, 8'd0);
        n         = 3'd0;
        res.slots = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n < 3'd3)
            begin
                res.slots[n[1:0]] = cand_t[i];
                n                 = n + 3'd1;
            end
        end
        res.count = n[1:0];
    end

    // next scanner state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        if (fire)
        begin
            if (last)
            begin
                state_next.mode     = letok_pkg::MODE_IDLE;
                state_next.window   = '0;
                state_next.name_len = '0;
                state_next.start    = '0;
                pos_next            = '0;
            end
            else
            begin
                state_next = step_a.st;
                pos_next   = pos_after;
            end
        end
    end

    // scanner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode     <= letok_pkg::MODE_IDLE;
            state_reg.window   <= '0;
            state_reg.name_len <= '0;
            state_reg.start    <= '0;
            pos_reg            <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef SYNTH
    // an end beat always yields at least its end token
    a_end_has_token: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |-> res.count != 2'd0)
        else $error("end beat produced no token");

    // an end beat leaves the scanner cleared
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> state_reg.mode == letok_pkg::MODE_IDLE && pos_reg == '0)
        else $error("scanner not cleared after end beat");

    // position only moves on an accepted beat
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg))
        else $error("position moved without a beat");
`endif

endmodule

`default_nettype wire

[sv/letok_outbuf.sv]
// result register holding the tokens of one beat and sending them one by one
`default_nettype none

module letok_outbuf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire letok_pkg::bundle_t  res,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output letok_pkg::token_t        out_tok,
    output logic                     out_last
);

    letok_pkg::token_t [2:0] slot_reg, slot_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    in_fire;
    logic                    out_fire;

    // handshakes: a new beat may land as the last pending token leaves
    always_comb
    begin
        out_valid = cnt_reg != 2'd0;
        out_last  = cnt_reg == 2'd1;
        out_tok   = slot_reg[0];
        in_ready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
        in_fire   = in_valid && in_ready;
        out_fire  = out_valid && out_ready;
    end

    // load on input beat, shift down on output beat
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (in_fire)
        begin
            slot_next = res.slots;
            cnt_next  = res.count;
        end
        else if (out_fire)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

`ifndef SYNTH
    // an accepted beat loads its full token count
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> cnt_reg == $past(res.count))
        else $error("token count not loaded");

    // each sent token alone drops the count by one
    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !in_fire |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("token count out of step");

    // input is only taken when no tokens are pending or as the last one leaves
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cnt_reg != 2'd0 |-> out_fire && out_last)
        else $error("beat accepted over pending tokens");
`endif

endmodule

`default_nettype wire

[sv/logic_expression_tokenizer_core.sv]
// output: the first token of a character beat is offered in the cycle after the beat is taken
// throughput: one character per cycle while each yields at most one token and the output is ready;
//   a character yielding up to 3 tokens holds the input until its last token leaves the single output port
// reset: rst_n asynchronously clears the scanner mode, counters and pending tokens
// top level of the logic expression tokenizer
`default_nettype none

module logic_expression_tokenizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] token_start, [23:16] token_length
    output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
    output logic             m_axis_tlast
);

    letok_pkg::bundle_t res;
    letok_pkg::token_t  tok;
    logic               fire;

    assign fire = s_axis_tvalid && s_axis_tready;

    // scanner
    letok_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (s_axis_tdata),
        .last      (s_axis_tlast),
        .res       (res)
    );

    // result register
    letok_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (tok),
        .out_last  (m_axis_tlast)
    );

    // output beat packing
    assign m_axis_tdata = {tok.length, tok.start};
    assign m_axis_tuser = tok.kind;

endmodule

`default_nettype wire

[sim/logic_expression_tokenizer_core_test.sv]
// self-checking testbench for the logic expression tokenizer core
`timescale 1ns / 100ps

module logic_expression_tokenizer_core_test;

    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned STUCK_LIMIT = 2000;

    // one character beat waiting to be sent
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    // one token as it should leave the block
    typedef struct packed {
        letok_pkg::kind_t kind;
        logic [15:0]      start;
        logic [7:0]       length;
        logic             last;
    } token_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    char_beat_t  pending_chars[$];
    logic [7:0]  expr_buf[$];
    token_exp_t  expected_tokens[$];
    token_exp_t  step_toks[$];

    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned random_beats = 0;
    int unsigned tokens_seen = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_gap = 0;
    int unsigned recv_calm = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned stuck_cycles = 0;

    // scanner state of the predictor
    letok_pkg::mode_t lex_mode = letok_pkg::MODE_IDLE;
    logic [39:0]      kw_window = '0;
    logic [7:0]       name_len = '0;
    logic [15:0]      char_pos = '0;
    logic [15:0]      tok_start = '0;

    string name_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    string tail_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    string sym_list[22] = '{"(", ")", "->", "<->", "True", "true", "T", "t", "False",
                            "false", "F", "f", "And", "and", "Or", "or", "Not", "not",
                            "TRUE", "Fals", "nott", "_"};

    logic_expression_tokenizer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [7:0] clip_len(logic [16:0] n);
        return (n > 17'd255) ? 8'd255 : n[7:0];
    endfunction

    // keyword spellings by length, anything else is a variable
    function automatic letok_pkg::kind_t name_kind(logic [39:0] w, logic [7:0] n);
        case (n)
            8'd1:
            begin
                if (w == "T" || w == "t") return letok_pkg::KIND_TRUE;
                if (w == "F" || w == "f") return letok_pkg::KIND_FALSE;
            end
            8'd2:
            begin
                if (w == "Or" || w == "or") return letok_pkg::KIND_OR;
            end
            8'd3:
            begin
                if (w == "And" || w == "and") return letok_pkg::KIND_AND;
                if (w == "Not" || w == "not") return letok_pkg::KIND_NOT;
            end
            8'd4:
            begin
                if (w == "True" || w == "true") return letok_pkg::KIND_TRUE;
            end
            8'd5:
            begin
                if (w == "False" || w == "false") return letok_pkg::KIND_FALSE;
            end
            default: ;
        endcase
        return letok_pkg::KIND_VARIABLE;
    endfunction

    task automatic put_token(letok_pkg::kind_t k, logic [15:0] st, logic [16:0] n);
        token_exp_t t;
        t.kind   = k;
        t.start  = st;
        t.length = clip_len(n);
        t.last   = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endtask

    task automatic close_name();
        put_token(name_kind(kw_window, name_len), tok_start, {9'd0, name_len});
        lex_mode  = letok_pkg::MODE_IDLE;
        kw_window = '0;
        name_len  = '0;
    endtask

    // error token spanning from the open token's start through p
    task automatic raise_error(logic [15:0] p);
        logic [15:0] span;
        span = p - tok_start;
        put_token(letok_pkg::KIND_ERROR, tok_start, {1'b0, span} + 17'd1);
        lex_mode = letok_pkg::MODE_ERROR;
    endtask

    task automatic idle_char(logic [7:0] c, logic [15:0] p);
        tok_start = p;
        if (is_blank(c))
            return;
        if (is_alpha(c) || c == "_")
        begin
            lex_mode  = letok_pkg::MODE_NAME;
            kw_window = {32'd0, c};
            name_len  = 8'd1;
        end
        else if (c == "(")
            put_token(letok_pkg::KIND_LPAREN, p, 17'd1);
        else if (c == ")")
            put_token(letok_pkg::KIND_RPAREN, p, 17'd1);
        else if (c == "-")
            lex_mode = letok_pkg::MODE_DASH;
        else if (c == "<")
            lex_mode = letok_pkg::MODE_LT;
        else
        begin
            put_token(letok_pkg::KIND_ERROR, p, 17'd1);
            lex_mode = letok_pkg::MODE_ERROR;
        end
    endtask

    task automatic scan_char(logic [7:0] c, logic [15:0] p);
        case (lex_mode)
            letok_pkg::MODE_IDLE:
                idle_char(c, p);
            letok_pkg::MODE_NAME:
            begin
                if (is_name_char(c))
                begin
                    if (name_len < 8'd5)
                        kw_window = {kw_window[31:0], c};
                    if (name_len < letok_pkg::MAX_NAME_LENGTH)
                        name_len = name_len + 8'd1;
                end
                else
                begin
                    close_name();
                    idle_char(c, p);
                end
            end
            letok_pkg::MODE_DASH:
            begin
                if (c == ">")
                begin
                    put_token(letok_pkg::KIND_THEN, tok_start, 17'd2);
                    lex_mode = letok_pkg::MODE_IDLE;
                end
                else
                    raise_error(p);
            end
            letok_pkg::MODE_LT:
            begin
                if (c == "-")
                    lex_mode = letok_pkg::MODE_LTDASH;
                else
                    raise_error(p);
            end
            letok_pkg::MODE_LTDASH:
            begin
                if (c == ">")
                begin
                    put_token(letok_pkg::KIND_EQUIV, tok_start, 17'd3);
                    lex_mode = letok_pkg::MODE_IDLE;
                end
                else
                    raise_error(p);
            end
            default:
                lex_mode = letok_pkg::MODE_ERROR;
        endcase
    endtask

    // tokens caused by one accepted character beat
    task automatic predict_char(logic [7:0] c, logic last);
        logic [15:0] p;
        logic [15:0] nxt;
        p   = char_pos;
        nxt = p + 16'd1;
        step_toks.delete();
        scan_char(c, p);
        char_pos = nxt;
        // end of expression behaves like one trailing blank
        if (last)
        begin
            scan_char(8'd32, nxt);
            put_token(letok_pkg::KIND_END, nxt, 17'd0);
            lex_mode  = letok_pkg::MODE_IDLE;
            kw_window = '0;
            name_len  = '0;
            char_pos  = '0;
            tok_start = '0;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_blank();
        if ($urandom_range(0, 3) != 0) return 8'd32;
        return 8'($urandom_range(9, 13));
    endfunction

    task automatic add_char(logic [7:0] c);
        expr_buf.insert(expr_buf.size(), c);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_blanks();
        int unsigned k;
        k = $urandom_range(1, 2);
        for (int i = 0; i < k; i++)
            add_char(any_blank());
    endtask

    task automatic add_token();
        int unsigned k;
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(0, 7);
            add_char(name_chars[$urandom_range(0, name_chars.len() - 1)]);
            for (int i = 0; i < k; i++)
                add_char(tail_chars[$urandom_range(0, tail_chars.len() - 1)]);
        end
        else
            add_text(sym_list[$urandom_range(0, 21)]);
    endtask

    // move the assembled expression to the send queue, end flag on its last beat
    task automatic flush_expr();
        char_beat_t cb;
        if (expr_buf.size() == 0)
            add_char(8'd32);
        foreach (expr_buf[i])
        begin
            cb.code = expr_buf[i];
            cb.last = (i == expr_buf.size() - 1);
            pending_chars.insert(pending_chars.size(), cb);
        end
        beats_queued += expr_buf.size();
        expr_buf.delete();
    endtask

    task automatic gen_expression();
        int unsigned style;
        int unsigned n;
        style = $urandom_range(0, 9);
        if (style <= 6)
        begin
            // well-formed token sequence
            n = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
                add_blanks();
            for (int i = 0; i < n; i++)
            begin
                add_token();
                if ($urandom_range(0, 3) != 0)
                    add_blanks();
            end
        end
        else if (style == 7)
        begin
            // raw byte noise
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_char(8'($urandom_range(0, 255)));
        end
        else if (style == 8)
        begin
            // valid prefix then a broken arrow, possibly with dropped tail
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                add_token();
                add_blanks();
            end
            case ($urandom_range(0, 5))
                0:
                begin
                    add_text("-");
                    add_char(8'($urandom_range(0, 255)));
                end
                1:
                begin
                    add_text("<");
                    add_char(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    add_text("<-");
                    add_char(8'($urandom_range(0, 255)));
                end
                3: add_text("-");
                4: add_text("<");
                default: add_text("<-");
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                add_blanks();
                add_token();
            end
        end
        else
        begin
            // short expression: one or two blanks, or a single random byte
            if ($urandom_range(0, 1) == 1)
                add_blanks();
            else
                add_char(8'($urandom_range(0, 255)));
        end
        random_beats += (expr_buf.size() == 0) ? 1 : expr_buf.size();
        flush_expr();
    endtask

    // sender pause until every queued beat is taken and every token has come
    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(beats_taken == beats_queued && expected_tokens.size() == 0));
    endtask

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", what);
    endtask

    // ---------------------------------------------------------------
    // character driver
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : char_driver
        char_beat_t beat;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                beat = pending_chars.pop_front();
                s_axis_tdata  <= beat.code;
                s_axis_tlast  <= beat.last;
                s_axis_tvalid <= 1'b1;
                send_gap      <= (send_calm > 0) ? 0 : idle_len();
                send_calm     <= (send_calm > 0) ? send_calm - 1 :
                                 (($urandom_range(0, 15) == 0) ? 40 : 0);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // token receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && tokens_seen >= 34)
        begin
            hold_left     <= LONG_HOLD;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_gap      <= (recv_calm > 0) ? 0 : idle_len();
            recv_calm     <= (recv_calm > 0) ? recv_calm - 1 :
                             (($urandom_range(0, 31) == 0) ? 60 : 0);
        end
    end

    // accepted character beats feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_char(s_axis_tdata, s_axis_tlast);
            beats_taken++;
        end
    end

    // accepted tokens against the oldest expectation
    always @(posedge clk)
    begin : token_check
        token_exp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tokens_seen <= tokens_seen + 1;
            if (expected_tokens.size() == 0)
                note_failure($sformatf("unexpected token kind %0d start %0d length %0d",
                                       m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16]));
            else
            begin
                want = expected_tokens.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata[15:0] !== want.start ||
                    m_axis_tdata[23:16] !== want.length || m_axis_tlast !== want.last)
                    note_failure($sformatf(
                        "expected kind %0d start %0d length %0d last %0b, got %0d %0d %0d %0b",
                        want.kind, want.start, want.length, want.last, m_axis_tuser,
                        m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tlast));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // parentheses, arrows, keywords, identifier closed by the end flag
        add_text("(a)");
        flush_expr();
        add_text("t->F");
        flush_expr();
        add_text("or<->_9");
        flush_expr();
        // lone dash and broken equivalence, mid-expression and at the end
        add_text("-x");
        flush_expr();
        add_text("<a");
        flush_expr();
        add_text("<-");
        flush_expr();
        add_text("<");
        flush_expr();
        add_text("-");
        flush_expr();
        // stray characters, the byte extremes, and dropping after an error
        add_char(8'h00);
        flush_expr();
        add_text("#ab");
        flush_expr();
        add_char(8'hFF);
        flush_expr();
        wait_drained();

        // identifier long enough to saturate the length field
        add_text("v");
        for (int i = 0; i < 259; i++)
            add_char(tail_chars[$urandom_range(0, tail_chars.len() - 1)]);
        add_text(")");
        flush_expr();

        // random expressions in two halves with a full drain between
        while (random_beats < 45)
            gen_expression();
        wait_drained();
        while (random_beats < 90)
            gen_expression();
        wait_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
